// ===== sv/scfc_pkg.sv =====
package scfc_pkg;

  localparam int unsigned ENTRY_COUNT = 64;
  localparam int unsigned IDX_W = $clog2(ENTRY_COUNT);
  localparam int unsigned STEP_W = $clog2(ENTRY_COUNT + 1);

  localparam logic [7:0] CHAIN_END = 8'hFF;
  localparam logic [7:0] ENTRY_ABSORBED = 8'hFE;
  localparam logic [15:0] MASK_ALL = 16'hFFFF;

  typedef enum logic [1:0] {
    OP_LOAD_ENTRY = 2'd0,
    OP_LOAD_FREE  = 2'd1,
    OP_FREE_ROWS  = 2'd2,
    OP_NOP        = 2'd3
  } op_e;

  typedef enum logic {
    CFG_CHAIN_HEAD    = 1'b0,
    CFG_ROWS_PER_SLOT = 1'b1
  } cfg_idx_e;

  typedef struct packed {
    logic [1:0]  op;
    logic [7:0]  entry_index;
    logic [15:0] load_mask;
    logic [4:0]  load_best_run;
    logic [7:0]  load_next;
    logic [7:0]  load_rows;
    logic [7:0]  row;
    logic [7:0]  rows_to_free;
  } in_item_t;

  typedef struct packed {
    logic        found;
    logic [15:0] new_mask;
    logic [4:0]  new_best_run;
    logic [7:0]  free_row_total;
    logic        merged_prev;
    logic        merged_next;
  } out_item_t;

  typedef struct packed {
    logic [15:0] mask;
    logic [4:0]  best;
    logic [7:0]  next;
    logic [7:0]  rows;
  } entry_t;

  typedef enum logic [4:0] {
    CMD_IDLE,
    CMD_ACCEPT,
    CMD_WALK_RD,
    CMD_WALK_DATA,
    CMD_SCAN,
    CMD_UPDATE,
    CMD_PREV_RD,
    CMD_PREV_DATA,
    CMD_IDX_RD,
    CMD_IDX_DATA,
    CMD_CUR_RD,
    CMD_CUR_DATA,
    CMD_NXT_RD,
    CMD_NXT_DATA,
    CMD_ABS_RD,
    CMD_ABS_DATA,
    CMD_FINISH
  } dp_cmd_e;

  typedef struct packed {
    logic walk_end;
    logic base_hit;
    logic scan_done;
    logic mask_zero;
    logic prev_none;
    logic rd_empty;
    logic nx_ok;
    logic out_busy;
  } dp_status_t;

endpackage

// ===== sv/scfc_ram.sv =====
module scfc_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ===== sv/scfc_dp.sv =====
module scfc_dp (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic                cfg_index_i,
  input  logic [7:0]          cfg_wdata_i,
  input  scfc_pkg::in_item_t  in_data_i,
  input  scfc_pkg::dp_cmd_e   cmd_i,
  output scfc_pkg::dp_status_t status_o,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output scfc_pkg::out_item_t out_data_o
);

  localparam logic [7:0] EntryLimit = 8'(scfc_pkg::ENTRY_COUNT);
  localparam logic [scfc_pkg::STEP_W-1:0] StepLimit =
    scfc_pkg::STEP_W'(scfc_pkg::ENTRY_COUNT);

  logic [7:0] head_q;
  logic [4:0] rps_q;
  logic [7:0] free_q, free_d;

  logic [7:0] row_q, nfree_q;
  logic [7:0] idx_q, prev_q, cur_q, base_q;
  logic [scfc_pkg::STEP_W-1:0] steps_q;
  scfc_pkg::entry_t ent_q;
  logic [15:0] m_q;
  logic [4:0] scan_i_q, run_q, best_q;
  logic found_q, mprev_q, mnext_q;

  logic out_valid_q;
  scfc_pkg::out_item_t out_q;

  logic we;
  logic [scfc_pkg::IDX_W-1:0] waddr, raddr;
  scfc_pkg::entry_t wdata, rd;

  logic [15:0] toggle;
  logic [8:0] row_end;
  logic [4:0] run_inc;

  scfc_ram #(
    .WIDTH($bits(scfc_pkg::entry_t)),
    .DEPTH(scfc_pkg::ENTRY_COUNT)
  ) u_ram (
    .clk_i  (clk_i),
    .we_i   (we),
    .waddr_i(waddr),
    .wdata_i(wdata),
    .raddr_i(raddr),
    .rdata_o(rd)
  );

  // bits row .. row+n-1 within the 16-bit mask
  assign row_end = {1'b0, row_q} + {1'b0, nfree_q};
  always_comb begin
    for (int k = 0; k < 16; k++) begin
      toggle[k] = (9'(k) >= {1'b0, row_q}) && (9'(k) < row_end);
    end
  end

  assign run_inc = run_q + 5'd1;

  always_comb begin
    we    = 1'b0;
    waddr = idx_q[scfc_pkg::IDX_W-1:0];
    wdata = ent_q;
    raddr = idx_q[scfc_pkg::IDX_W-1:0];
    unique case (cmd_i)
      scfc_pkg::CMD_ACCEPT: begin
        we    = (in_data_i.op == scfc_pkg::OP_LOAD_ENTRY) && (in_data_i.entry_index < EntryLimit);
        waddr = in_data_i.entry_index[scfc_pkg::IDX_W-1:0];
        wdata = '{mask: in_data_i.load_mask, best: in_data_i.load_best_run,
                  next: in_data_i.load_next, rows: in_data_i.load_rows};
      end
      scfc_pkg::CMD_UPDATE: begin
        we    = 1'b1;
        wdata = '{mask: m_q, best: best_q, next: ent_q.next, rows: ent_q.rows};
      end
      scfc_pkg::CMD_PREV_RD: raddr = prev_q[scfc_pkg::IDX_W-1:0];
      scfc_pkg::CMD_PREV_DATA: begin
        we    = (rd.mask == '0);
        waddr = prev_q[scfc_pkg::IDX_W-1:0];
        wdata = '{mask: rd.mask, best: rd.best, next: ent_q.next,
                  rows: rd.rows + ent_q.rows};
      end
      scfc_pkg::CMD_IDX_DATA, scfc_pkg::CMD_ABS_DATA: begin
        we    = 1'b1;
        wdata = '{mask: rd.mask, best: rd.best, next: scfc_pkg::ENTRY_ABSORBED,
                  rows: scfc_pkg::ENTRY_ABSORBED};
      end
      scfc_pkg::CMD_CUR_RD: raddr = cur_q[scfc_pkg::IDX_W-1:0];
      scfc_pkg::CMD_NXT_DATA: begin
        we    = (rd.mask == '0);
        waddr = cur_q[scfc_pkg::IDX_W-1:0];
        wdata = '{mask: ent_q.mask, best: ent_q.best, next: rd.next,
                  rows: ent_q.rows + rd.rows};
      end
      default: ;
    endcase
  end

  always_comb begin
    free_d = free_q;
    if (cmd_i == scfc_pkg::CMD_ACCEPT && in_data_i.op == scfc_pkg::OP_LOAD_FREE) begin
      free_d = in_data_i.load_rows;
    end else if (cmd_i == scfc_pkg::CMD_UPDATE && m_q == '0) begin
      free_d = free_q + ent_q.rows;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q      <= scfc_pkg::CHAIN_END;
      rps_q       <= 5'd16;
      free_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        if (cfg_index_i == scfc_pkg::CFG_CHAIN_HEAD) begin
          head_q <= cfg_wdata_i;
        end else begin
          rps_q <= cfg_wdata_i[4:0];
        end
      end
      free_q <= free_d;
      if (cmd_i == scfc_pkg::CMD_FINISH) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    unique case (cmd_i)
      scfc_pkg::CMD_ACCEPT: begin
        row_q   <= in_data_i.row;
        nfree_q <= in_data_i.rows_to_free;
        idx_q   <= head_q;
        prev_q  <= scfc_pkg::CHAIN_END;
        base_q  <= '0;
        steps_q <= '0;
        m_q     <= '0;
        best_q  <= '0;
        found_q <= 1'b0;
        mprev_q <= 1'b0;
        mnext_q <= 1'b0;
      end
      scfc_pkg::CMD_WALK_DATA: begin
        if (base_q == row_q) begin
          ent_q    <= rd;
          m_q      <= rd.mask ^ toggle;
          scan_i_q <= '0;
          run_q    <= '0;
          best_q   <= '0;
        end else begin
          prev_q  <= idx_q;
          base_q  <= base_q + rd.rows;
          idx_q   <= rd.next;
          steps_q <= steps_q + 1'b1;
        end
      end
      scfc_pkg::CMD_SCAN: begin
        if (scan_i_q < rps_q) begin
          scan_i_q <= scan_i_q + 5'd1;
          if (scan_i_q < 5'd16 && m_q[scan_i_q[3:0]]) begin
            run_q <= '0;
          end else begin
            run_q <= run_inc;
            if (run_inc >= best_q) begin
              best_q <= run_inc;
            end
          end
        end
      end
      scfc_pkg::CMD_UPDATE: begin
        found_q <= 1'b1;
        cur_q   <= idx_q;
      end
      scfc_pkg::CMD_PREV_DATA: begin
        if (rd.mask == '0) begin
          mprev_q <= 1'b1;
          cur_q   <= prev_q;
        end
      end
      scfc_pkg::CMD_CUR_DATA: begin
        ent_q <= rd;
        idx_q <= rd.next;
      end
      scfc_pkg::CMD_NXT_DATA: begin
        if (rd.mask == '0) begin
          mnext_q <= 1'b1;
        end
      end
      scfc_pkg::CMD_FINISH: begin
        out_q <= '{found: found_q, new_mask: m_q, new_best_run: best_q,
                   free_row_total: free_q, merged_prev: mprev_q, merged_next: mnext_q};
      end
      default: ;
    endcase
  end

  assign status_o = '{
    walk_end:  (idx_q >= EntryLimit) || (steps_q >= StepLimit),
    base_hit:  (base_q == row_q),
    scan_done: (scan_i_q >= rps_q),
    mask_zero: (m_q == '0),
    prev_none: (prev_q == scfc_pkg::CHAIN_END),
    rd_empty:  (rd.mask == '0),
    nx_ok:     (rd.next < EntryLimit),
    out_busy:  out_valid_q && out_stall_i
  };

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

// ===== sv/scfc_ctrl.sv =====
module scfc_ctrl (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  logic [1:0]           in_op_i,
  input  scfc_pkg::dp_status_t status_i,
  output scfc_pkg::dp_cmd_e    cmd_o
);

  typedef enum logic [4:0] {
    S_IDLE,
    S_WALK_RD,
    S_WALK_DATA,
    S_SCAN,
    S_UPDATE,
    S_PREV_RD,
    S_PREV_DATA,
    S_IDX_RD,
    S_IDX_DATA,
    S_CUR_RD,
    S_CUR_DATA,
    S_NXT_RD,
    S_NXT_DATA,
    S_ABS_RD,
    S_ABS_DATA,
    S_FINISH
  } state_e;

  state_e state_q, state_d;
  scfc_pkg::dp_cmd_e cmd;

  always_comb begin
    state_d = state_q;
    cmd     = scfc_pkg::CMD_IDLE;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd     = scfc_pkg::CMD_ACCEPT;
          state_d = (in_op_i == scfc_pkg::OP_FREE_ROWS) ? S_WALK_RD : S_FINISH;
        end
      end
      S_WALK_RD: begin
        if (status_i.walk_end) begin
          state_d = S_FINISH;
        end else begin
          cmd     = scfc_pkg::CMD_WALK_RD;
          state_d = S_WALK_DATA;
        end
      end
      S_WALK_DATA: begin
        cmd     = scfc_pkg::CMD_WALK_DATA;
        state_d = status_i.base_hit ? S_SCAN : S_WALK_RD;
      end
      S_SCAN: begin
        cmd = scfc_pkg::CMD_SCAN;
        if (status_i.scan_done) begin
          state_d = S_UPDATE;
        end
      end
      S_UPDATE: begin
        cmd = scfc_pkg::CMD_UPDATE;
        if (!status_i.mask_zero) begin
          state_d = S_FINISH;
        end else if (status_i.prev_none) begin
          state_d = S_CUR_RD;
        end else begin
          state_d = S_PREV_RD;
        end
      end
      S_PREV_RD: begin
        cmd     = scfc_pkg::CMD_PREV_RD;
        state_d = S_PREV_DATA;
      end
      S_PREV_DATA: begin
        cmd     = scfc_pkg::CMD_PREV_DATA;
        state_d = status_i.rd_empty ? S_IDX_RD : S_CUR_RD;
      end
      S_IDX_RD: begin
        cmd     = scfc_pkg::CMD_IDX_RD;
        state_d = S_IDX_DATA;
      end
      S_IDX_DATA: begin
        cmd     = scfc_pkg::CMD_IDX_DATA;
        state_d = S_CUR_RD;
      end
      S_CUR_RD: begin
        cmd     = scfc_pkg::CMD_CUR_RD;
        state_d = S_CUR_DATA;
      end
      S_CUR_DATA: begin
        cmd     = scfc_pkg::CMD_CUR_DATA;
        state_d = status_i.nx_ok ? S_NXT_RD : S_FINISH;
      end
      S_NXT_RD: begin
        cmd     = scfc_pkg::CMD_NXT_RD;
        state_d = S_NXT_DATA;
      end
      S_NXT_DATA: begin
        cmd     = scfc_pkg::CMD_NXT_DATA;
        state_d = status_i.rd_empty ? S_ABS_RD : S_FINISH;
      end
      S_ABS_RD: begin
        cmd     = scfc_pkg::CMD_ABS_RD;
        state_d = S_ABS_DATA;
      end
      S_ABS_DATA: begin
        cmd     = scfc_pkg::CMD_ABS_DATA;
        state_d = S_FINISH;
      end
      S_FINISH: begin
        if (!status_i.out_busy) begin
          cmd     = scfc_pkg::CMD_FINISH;
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  assign in_stall_o = (state_q != S_IDLE);
  assign cmd_o      = cmd;

endmodule

// ===== sv/slot_chain_free_coalesce_unit.sv =====
// Slot chain allocator with row freeing and coalescing of empty neighbors. One beat in
// gives one beat out. Load beats go from accept straight to posting the result. A free
// beat walks the chain through a single table memory, one read per entry visited (up to
// 64); if it finds the row, it scans the mask one bit per cycle, then does the entry
// update and merge writes, each merge step a read followed by a write, plus an accept
// step and a step to post the result. Posting waits while a previous result is stalled.
// Table entries that were never loaded must not be reached.
module slot_chain_free_coalesce_unit (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic                cfg_index_i,
  input  logic [7:0]          cfg_wdata_i,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  scfc_pkg::in_item_t  in_data_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output scfc_pkg::out_item_t out_data_o
);

  scfc_pkg::dp_cmd_e    cmd;
  scfc_pkg::dp_status_t status;

  scfc_ctrl u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_valid_i(in_valid_i),
    .in_stall_o(in_stall_o),
    .in_op_i   (in_data_i.op),
    .status_i  (status),
    .cmd_o     (cmd)
  );

  scfc_dp u_dp (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_index_i(cfg_index_i),
    .cfg_wdata_i(cfg_wdata_i),
    .in_data_i  (in_data_i),
    .cmd_i      (cmd),
    .status_o   (status),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_data_o (out_data_o)
  );

endmodule
